// File: hw/rtl/partition_unrank_core_macros.svh
// ----------------------------------------------------------------------------
// partition_unrank_core_macros
// assertion macros shared by the partition unrank rtl
// ----------------------------------------------------------------------------
`ifndef PARTITION_UNRANK_CORE_MACROS_SVH
`define PARTITION_UNRANK_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("partition unrank check failed");

// next-cycle implication, checked out of reset
`define PU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("partition unrank check failed");

`endif

// File: hw/rtl/pu_pkg.sv
// ----------------------------------------------------------------------------
// pu_pkg
// widths, defaults and codes for the partition unrank core
// ----------------------------------------------------------------------------
package pu_pkg;

    localparam int MAX_TOTAL_DEF = 64;
    localparam int TOTAL_W       = 7;
    localparam int RANK_W        = 21;
    localparam int PART_W        = 7;
    localparam int CNT_W         = 21;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_IDLE,
        ST_CHECK,
        ST_WALK
    } t_state;

    // where a count comes from: table memory or a fixed boundary value
    typedef enum logic [1:0] {
        SRC_MEM,
        SRC_ONE,
        SRC_ZERO
    } t_src;

endpackage

// File: hw/rtl/pu_ram.sv
// ----------------------------------------------------------------------------
// pu_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pu_ram #(
    parameter  int WIDTH  = 21,
    parameter  int DEPTH  = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/partition_unrank_core.sv
// ----------------------------------------------------------------------------
// partition_unrank_core
// lexicographic unranking of integer partitions from a table of counts
// ----------------------------------------------------------------------------
// After reset the core fills its count table with busy high, one table
// entry per cycle. Then an item is taken when start is high and busy is low.
// Each part comes out on o_part for one cycle with o_valid high, smallest
// first, o_last on the final one; the receiver cannot stall and must take
// every result. A total of zero or above MAX_TOTAL gives one error result the
// cycle after accept and the core stays ready. Otherwise a check state first
// compares the rank against the partition count, then the walk tries one
// candidate part per cycle, one table memory read each. A rank that is too
// large ends after the check with a single error result.
// ----------------------------------------------------------------------------
`include "partition_unrank_core_macros.svh"

module partition_unrank_core #(
    parameter int MAX_TOTAL = pu_pkg::MAX_TOTAL_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [pu_pkg::TOTAL_W-1:0]  i_total,
    input  logic [pu_pkg::RANK_W-1:0]   i_rank,
    output logic                        busy,
    output logic                        o_valid,
    output logic [pu_pkg::PART_W-1:0]   o_part,
    output logic                        o_last,
    output logic                        o_rank_error
);

    import pu_pkg::*;

    localparam int QW     = $clog2(MAX_TOTAL + 2);
    localparam int IW     = $clog2(MAX_TOTAL);
    localparam int ADDR_W = 2 * IW;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [QW-1:0] Q_ONE = QW'(1);
    localparam logic [QW-1:0] Q_MAX = QW'(MAX_TOTAL);

    // table entry for x >= y >= 1 lives at {x-1, y-1}
    function automatic logic [ADDR_W-1:0] addr_of(input logic [QW-1:0] x,
                                                  input logic [QW-1:0] y);
        logic [QW-1:0] xm;
        logic [QW-1:0] ym;
        xm = x - Q_ONE;
        ym = y - Q_ONE;
        return {xm[IW-1:0], ym[IW-1:0]};
    endfunction

    function automatic t_src src_of(input logic [QW-1:0] x, input logic [QW-1:0] y);
        t_src s;
        if (x == '0) begin
            s = SRC_ONE;
        end else if (y > x) begin
            s = SRC_ZERO;
        end else begin
            s = SRC_MEM;
        end
        return s;
    endfunction

    t_state             r_state, n_state;
    t_src               r_src, n_src;
    logic [QW-1:0]      r_q, n_q;
    logic [QW-1:0]      r_i, n_i;
    logic [RANK_W-1:0]  r_rank, n_rank;

    // fill sequencer: issue stage and write-back stage
    logic [QW-1:0]      r_fx, n_fx;
    logic [QW-1:0]      r_fy, n_fy;
    logic               r_f_done, n_f_done;
    logic               r_f1_valid, n_f1_valid;
    logic [QW-1:0]      r_f1_x, n_f1_x;
    logic [QW-1:0]      r_f1_y, n_f1_y;
    logic               r_f1_first, n_f1_first;
    logic [CNT_W-1:0]   r_acc, n_acc;

    logic               r_out_valid, n_out_valid;
    logic [PART_W-1:0]  r_part, n_part;
    logic               r_last, n_last;
    logic               r_err, n_err;

    logic [QW-1:0]      lk_x, lk_y;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [CNT_W-1:0]   rd_data;
    logic [CNT_W-1:0]   c_val;
    logic [QW-1:0]      q_sub;
    logic [QW-1:0]      i_inc;
    logic [QW-1:0]      fx_inc;

    pu_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (n_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        unique case (r_src)
            SRC_MEM:  c_val = rd_data;
            SRC_ONE:  c_val = CNT_W'(1);
            SRC_ZERO: c_val = '0;
            default:  c_val = '0;
        endcase
    end

    assign q_sub  = r_q - r_i;
    assign i_inc  = r_i + Q_ONE;
    assign fx_inc = r_fx + Q_ONE;

    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_i         = r_i;
        n_rank      = r_rank;
        n_fx        = r_fx;
        n_fy        = r_fy;
        n_f_done    = r_f_done;
        n_f1_valid  = 1'b0;
        n_f1_x      = r_f1_x;
        n_f1_y      = r_f1_y;
        n_f1_first  = r_f1_first;
        n_acc       = r_acc;
        n_out_valid = 1'b0;
        n_part      = r_part;
        n_last      = r_last;
        n_err       = r_err;
        lk_x        = '0;
        lk_y        = '0;
        wr_en       = 1'b0;
        wr_addr     = '0;

        unique case (r_state)
            ST_FILL: begin
                if (!r_f_done) begin
                    lk_x       = r_fx - r_fy;
                    lk_y       = r_fy;
                    n_f1_valid = 1'b1;
                    n_f1_x     = r_fx;
                    n_f1_y     = r_fy;
                    n_f1_first = (r_fx == r_fy);
                    if (r_fy == Q_ONE) begin
                        if (r_fx == Q_MAX) begin
                            n_f_done = 1'b1;
                        end else begin
                            n_fx = fx_inc;
                            n_fy = fx_inc;
                        end
                    end else begin
                        n_fy = r_fy - Q_ONE;
                    end
                end
                if (r_f1_valid) begin
                    n_acc   = (r_f1_first ? '0 : r_acc) + c_val;
                    wr_en   = 1'b1;
                    wr_addr = addr_of(r_f1_x, r_f1_y);
                    if (r_f1_x == Q_MAX && r_f1_y == Q_ONE) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_total == '0 || i_total > TOTAL_W'(MAX_TOTAL)) begin
                        n_out_valid = 1'b1;
                        n_part      = '0;
                        n_last      = 1'b1;
                        n_err       = 1'b1;
                    end else begin
                        n_state = ST_CHECK;
                        n_q     = QW'(i_total);
                        n_rank  = i_rank;
                        lk_x    = QW'(i_total);
                        lk_y    = Q_ONE;
                    end
                end
            end
            ST_CHECK: begin
                if (r_rank >= c_val) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_part      = '0;
                    n_last      = 1'b1;
                    n_err       = 1'b1;
                end else begin
                    n_state = ST_WALK;
                    n_i     = Q_ONE;
                    lk_x    = r_q - Q_ONE;
                    lk_y    = Q_ONE;
                end
            end
            ST_WALK: begin
                if (r_i > r_q) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_part      = '0;
                    n_last      = 1'b1;
                    n_err       = 1'b1;
                end else if (r_rank < c_val) begin
                    n_out_valid = 1'b1;
                    n_part      = PART_W'(r_i);
                    n_last      = (q_sub == '0);
                    n_err       = 1'b0;
                    n_q         = q_sub;
                    lk_x        = q_sub - r_i;
                    lk_y        = r_i;
                    if (q_sub == '0) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_rank = r_rank - c_val;
                    n_i    = i_inc;
                    lk_x   = r_q - i_inc;
                    lk_y   = i_inc;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        rd_addr = addr_of(lk_x, lk_y);
        n_src   = src_of(lk_x, lk_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_fx        <= Q_ONE;
            r_fy        <= Q_ONE;
            r_f_done    <= 1'b0;
            r_f1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fx        <= n_fx;
            r_fy        <= n_fy;
            r_f_done    <= n_f_done;
            r_f1_valid  <= n_f1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_q        <= n_q;
        r_i        <= n_i;
        r_rank     <= n_rank;
        r_f1_x     <= n_f1_x;
        r_f1_y     <= n_f1_y;
        r_f1_first <= n_f1_first;
        r_acc      <= n_acc;
        r_part     <= n_part;
        r_last     <= n_last;
        r_err      <= n_err;
    end

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_part       = r_part;
    assign o_last       = r_last;
    assign o_rank_error = r_err;

    `PU_ASSERT_SAME(a_err_shape, i_clk, i_rst_n, o_valid && o_rank_error, o_last && o_part == '0)
    `PU_ASSERT_SAME(a_no_out_in_fill, i_clk, i_rst_n, r_state == ST_FILL, !o_valid)
    `PU_ASSERT_SAME(a_last_frees_core, i_clk, i_rst_n, o_valid && o_last, !busy)
    `PU_ASSERT_NEXT(a_part_grows, i_clk, i_rst_n, o_valid && !o_last, r_i >= $past(r_i))

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for partition_unrank_core: a scoreboard rebuilds the
// count table, unranks every accepted item on its own and compares each part
// the core emits, in order; directed corner items come first, then random ones
// ----------------------------------------------------------------------------

class unrank_scoreboard;
    localparam int MAXT = pu_pkg::MAX_TOTAL_DEF;

    typedef bit [pu_pkg::CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [pu_pkg::PART_W-1:0] part;
        logic                      last;
        logic                      rank_error;
    } t_part_res;

    t_cnt                   part_counts [0:MAXT][1:MAXT+1];
    t_part_res              parts_due [$];
    int                     fails;
    int                     items;
    int                     parts_seen;
    int                     error_answers;

    function new();
        t_cnt above;
        fails = 0;
        items = 0;
        parts_seen = 0;
        error_answers = 0;
        for (int y = MAXT + 1; y >= 1; y--) begin
            part_counts[0][y] = t_cnt'(1);
            for (int x = 1; x <= MAXT; x++) begin
                if (y > x) begin
                    part_counts[x][y] = '0;
                end else begin
                    above = '0;
                    if (y + 1 <= MAXT + 1) begin
                        above = part_counts[x][y+1];
                    end
                    part_counts[x][y] = above + part_counts[x-y][y];
                end
            end
        end
    endfunction

    function int unsigned partition_count(int t);
        if (t < 1 || t > MAXT) begin
            return 0;
        end
        return 32'(part_counts[t][1]);
    endfunction

    function void push_part(int p, bit last, bit err);
        t_part_res res;
        res.part       = p[pu_pkg::PART_W-1:0];
        res.last       = last;
        res.rank_error = err;
        parts_due = {parts_due, res};
        if (err) begin
            error_answers++;
        end
    endfunction

    function void note_item(logic [pu_pkg::TOTAL_W-1:0] total, logic [pu_pkg::RANK_W-1:0] rank);
        int          t;
        int          q;
        int          m;
        int          k;
        bit          taken;
        int unsigned r;
        int unsigned c;
        items++;
        t = int'(total);
        r = 32'(rank);
        if (t == 0 || t > MAXT || r >= 32'(part_counts[t][1])) begin
            push_part(0, 1'b1, 1'b1);
            return;
        end
        q = t;
        m = 1;
        k = 0;
        while (q > 0 && k < MAXT) begin
            taken = 1'b0;
            for (int i = m; i <= q; i++) begin
                c = 32'(part_counts[q-i][i]);
                if (r < c) begin
                    q -= i;
                    m = i;
                    push_part(i, q == 0, 1'b0);
                    k++;
                    taken = 1'b1;
                    break;
                end
                r -= c;
            end
            if (!taken) begin
                push_part(0, 1'b1, 1'b1);
                break;
            end
        end
    endfunction

    function void check_part(logic [pu_pkg::PART_W-1:0] part, logic last, logic err);
        t_part_res want;
        parts_seen++;
        if (parts_due.size() == 0) begin
            $error("unexpected part: part=%0d last=%0d rank_error=%0d", part, last, err);
            fails++;
            return;
        end
        want = parts_due.pop_front();
        if (part !== want.part) begin
            $error("part: expected %0d, actual %0d", want.part, part);
            fails++;
        end
        if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            fails++;
        end
        if (err !== want.rank_error) begin
            $error("rank_error: expected %0d, actual %0d", want.rank_error, err);
            fails++;
        end
    endfunction

    function int parts_left();
        return parts_due.size();
    endfunction
endclass

module tb_top;
    import pu_pkg::*;

    localparam int RANDOM_ITEMS  = 250;
    localparam int CALM_ITEMS    = 50;
    localparam int DRAIN_CYCLES  = 300;
    localparam int STALL_LIMIT   = 20000;
    localparam int RANK_MAX      = (1 << RANK_W) - 1;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic [TOTAL_W-1:0] i_total = '0;
    logic [RANK_W-1:0]  i_rank  = '0;
    logic               busy;
    logic               o_valid;
    logic [PART_W-1:0]  o_part;
    logic               o_last;
    logic               o_rank_error;

    unrank_scoreboard sb = new();
    int               quiet_cycles = 0;

    partition_unrank_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_total      (i_total),
        .i_rank       (i_rank),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_part       (o_part),
        .o_last       (o_last),
        .o_rank_error (o_rank_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // accepted items and emitted parts, sampled at the edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0) begin
                sb.note_item(i_total, i_rank);
            end
            if (o_valid === 1'b1) begin
                sb.check_part(o_part, o_last, o_rank_error);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: %0d cycles with no item or part", STALL_LIMIT);
            $display("partition_unrank_core: mismatch");
            $finish;
        end
    end

    task automatic send_item(input logic [TOTAL_W-1:0] t, input logic [RANK_W-1:0] r);
        start   <= 1'b1;
        i_total <= t;
        i_rank  <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 3);
        start <= 1'b0;
        repeat (n) begin
            i_total <= TOTAL_W'($urandom);
            i_rank  <= RANK_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    task automatic send_random_item();
        int          sel;
        int          t;
        int unsigned cnt;
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            send_item(($urandom_range(0, 1) == 0) ? 7'd0 : 7'($urandom_range(65, 127)),
                      RANK_W'($urandom));
        end else begin
            t = (sel < 75) ? $urandom_range(1, 20) : $urandom_range(1, 64);
            cnt = sb.partition_count(t);
            if (sel < 10) begin
                send_item(TOTAL_W'(t), RANK_W'($urandom_range(RANK_MAX, cnt)));
            end else begin
                send_item(TOTAL_W'(t), RANK_W'($urandom_range(0, cnt - 1)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        send_item(7'd0, '0);
        send_item(7'd0, RANK_W'(RANK_MAX));
        send_item(7'd65, '0);
        send_item(7'd127, RANK_W'(RANK_MAX));
        send_item(7'd1, 21'd0);
        send_item(7'd1, 21'd1);
        for (int r = 0; r <= 2; r++) begin
            send_item(7'd2, RANK_W'(r));
        end
        for (int r = 0; r < 7; r++) begin
            send_item(7'd5, RANK_W'(r));
        end
        send_item(7'd64, 21'd0);
        send_item(7'd64, RANK_W'(sb.partition_count(64) - 1));
        send_item(7'd64, RANK_W'(sb.partition_count(64)));
        send_item(7'd64, RANK_W'(RANK_MAX));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n < RANDOM_ITEMS - CALM_ITEMS && (n % 40) < 28 && $urandom_range(0, 2) == 0) begin
                idle_burst();
            end
            send_random_item();
        end
        start <= 1'b0;

        while (sb.parts_left() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items, %0d parts checked, %0d error answers",
                 sb.items, sb.parts_seen, sb.error_answers);
        if (sb.fails == 0 && sb.parts_left() == 0) begin
            $display("partition_unrank_core: match");
        end else begin
            if (sb.parts_left() != 0) begin
                $error("%0d expected parts never emitted", sb.parts_left());
            end
            $display("partition_unrank_core: mismatch");
        end
        $finish;
    end
endmodule
